// File: hdl/sdz_pkg.sv
// Shared widths, constants and types of the stick radial dead zone scaler.
package sdz_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int SUM_W       = 2 * SAMPLE_BITS;
    localparam int ROOT_W      = SAMPLE_BITS;
    localparam int SQ_REM_W    = ROOT_W + 2;
    localparam int LEN100_W    = FRAC_BITS + 7;
    localparam int MAG_W       = FRAC_BITS + 1;
    localparam int DZ_W        = 7;
    localparam int SENS_W      = 8;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int NUM_W       = (2 * FRAC_BITS + 1 > LEN100_W + SENS_W)
                                 ? 2 * FRAC_BITS + 1 : LEN100_W + SENS_W;
    localparam int DEN_W       = (SAMPLE_BITS > 14) ? SAMPLE_BITS : 14;
    localparam int Q_W         = FRAC_BITS + 2;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;

    localparam logic [SAMPLE_BITS-1:0] ONE_VAL = SAMPLE_BITS'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = CFG_IDX_W'(1);

    localparam logic [DZ_W-1:0]   DZ_RESET   = DZ_W'(20);
    localparam logic [DZ_W-1:0]   DZ_MIN     = DZ_W'(5);
    localparam logic [DZ_W-1:0]   DZ_MAX     = DZ_W'(60);
    localparam logic [SENS_W-1:0] SENS_RESET = SENS_W'(100);
    localparam logic [SENS_W-1:0] SENS_MIN   = SENS_W'(50);
    localparam logic [SENS_W-1:0] SENS_MAX   = SENS_W'(200);

    typedef struct packed {
        logic [DZ_W-1:0]   dz;
        logic [SENS_W-1:0] sens;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] ax;
        logic [SAMPLE_BITS-1:0] ay;
        logic                   nx;
        logic                   ny;
        logic [ROOT_W-1:0]      len_full;
        logic                   dz_hit;
    } side_t;

    typedef struct packed {
        side_t                side;
        logic [LEN100_W-1:0]  diff;
    } item_t;

endpackage

// File: hdl/sdz_front.sv
// Front part: takes samples, forms the vector length and applies the dead zone test.
module sdz_front
    import sdz_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] stick_x,
    input  logic [SAMPLE_BITS-1:0] stick_y,
    input  logic                   fifo_full,
    output logic                   push,
    output item_t                  push_item
);

    logic en;

    logic                   a_v_reg;
    logic [SAMPLE_BITS-1:0] ax_reg, ay_reg;
    logic                   nx_reg, ny_reg;

    logic                   s_v_reg    [0:ROOT_W];
    logic [SUM_W-1:0]       s_rad_reg  [0:ROOT_W];
    logic [SQ_REM_W-1:0]    s_rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]      s_root_reg [0:ROOT_W];
    logic [SAMPLE_BITS-1:0] s_ax_reg   [0:ROOT_W];
    logic [SAMPLE_BITS-1:0] s_ay_reg   [0:ROOT_W];
    logic                   s_nx_reg   [0:ROOT_W];
    logic                   s_ny_reg   [0:ROOT_W];

    logic [SQ_REM_W-1:0]    rem_next   [1:ROOT_W];
    logic [ROOT_W-1:0]      root_next  [1:ROOT_W];
    logic [SQ_REM_W+1:0]    cur        [1:ROOT_W];
    logic [SQ_REM_W+1:0]    trial      [1:ROOT_W];

    logic                   cls_v_reg;
    item_t                  cls_reg;

    logic [SAMPLE_BITS-1:0] abs_x, abs_y;
    logic [SUM_W-1:0]       sum_sq;
    logic [ROOT_W-1:0]      len_cap;
    logic [LEN100_W-1:0]    len100;
    logic [LEN100_W-1:0]    dz_level;
    logic                   dz_hit;

    assign en        = !cls_v_reg || !fifo_full;
    assign in_ready  = en;
    assign push      = cls_v_reg && !fifo_full;
    assign push_item = cls_reg;

    assign abs_x  = stick_x[SAMPLE_BITS-1] ? SAMPLE_BITS'(0) - stick_x : stick_x;
    assign abs_y  = stick_y[SAMPLE_BITS-1] ? SAMPLE_BITS'(0) - stick_y : stick_y;
    assign sum_sq = SUM_W'(ax_reg) * SUM_W'(ax_reg) + SUM_W'(ay_reg) * SUM_W'(ay_reg);

    // One result bit of the square root per stage.
    always_comb
    begin
        for (int k = 1; k <= ROOT_W; k++)
        begin
            cur[k]   = {s_rem_reg[k-1], s_rad_reg[k-1][SUM_W-1:SUM_W-2]};
            trial[k] = (SQ_REM_W+2)'({s_root_reg[k-1], 2'b01});
            if (cur[k] >= trial[k])
            begin
                rem_next[k]  = SQ_REM_W'(cur[k] - trial[k]);
                root_next[k] = {s_root_reg[k-1][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = SQ_REM_W'(cur[k]);
                root_next[k] = {s_root_reg[k-1][ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign len_cap  = (s_root_reg[ROOT_W] > ONE_VAL) ? ONE_VAL : s_root_reg[ROOT_W];
    assign len100   = LEN100_W'(len_cap) * LEN100_W'(100);
    assign dz_level = LEN100_W'(cfg.dz) << FRAC_BITS;
    assign dz_hit   = len100 <= dz_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg   <= 1'b0;
            cls_v_reg <= 1'b0;
            for (int k = 0; k <= ROOT_W; k++)
            begin
                s_v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            a_v_reg    <= in_valid;
            s_v_reg[0] <= a_v_reg;
            for (int k = 1; k <= ROOT_W; k++)
            begin
                s_v_reg[k] <= s_v_reg[k-1];
            end
            cls_v_reg  <= s_v_reg[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= abs_x;
            ay_reg <= abs_y;
            nx_reg <= stick_x[SAMPLE_BITS-1];
            ny_reg <= stick_y[SAMPLE_BITS-1];

            s_rad_reg[0]  <= sum_sq;
            s_rem_reg[0]  <= '0;
            s_root_reg[0] <= '0;
            s_ax_reg[0]   <= ax_reg;
            s_ay_reg[0]   <= ay_reg;
            s_nx_reg[0]   <= nx_reg;
            s_ny_reg[0]   <= ny_reg;
            for (int k = 1; k <= ROOT_W; k++)
            begin
                s_rad_reg[k]  <= s_rad_reg[k-1] << 2;
                s_rem_reg[k]  <= rem_next[k];
                s_root_reg[k] <= root_next[k];
                s_ax_reg[k]   <= s_ax_reg[k-1];
                s_ay_reg[k]   <= s_ay_reg[k-1];
                s_nx_reg[k]   <= s_nx_reg[k-1];
                s_ny_reg[k]   <= s_ny_reg[k-1];
            end

            cls_reg.side.ax       <= s_ax_reg[ROOT_W];
            cls_reg.side.ay       <= s_ay_reg[ROOT_W];
            cls_reg.side.nx       <= s_nx_reg[ROOT_W];
            cls_reg.side.ny       <= s_ny_reg[ROOT_W];
            cls_reg.side.len_full <= s_root_reg[ROOT_W];
            cls_reg.side.dz_hit   <= dz_hit;
            cls_reg.diff          <= dz_hit ? '0 : len100 - dz_level;
        end
    end

endmodule

// File: hdl/sdz_fifo.sv
// Short queue of classified items between the front and back parts.
module sdz_fifo
    import sdz_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t pop_item,
    output logic  empty
);

    item_t              store_reg [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    assign full     = count_reg == (FIFO_AW+1)'(FIFO_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_item = store_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hdl/sdz_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
module sdz_div
    import sdz_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [Q_W-1:0]   out_q,
    output side_t            out_side
);

    logic             v_reg    [0:Q_W];
    logic [DEN_W-1:0] rem_reg  [0:Q_W];
    logic [Q_W-1:0]   low_reg  [0:Q_W];
    logic [Q_W-1:0]   q_reg    [0:Q_W];
    logic [DEN_W-1:0] den_reg  [0:Q_W];
    side_t            side_reg [0:Q_W];

    logic [DEN_W:0]   trial    [1:Q_W];
    logic [DEN_W-1:0] rem_next [1:Q_W];
    logic             q_bit    [1:Q_W];

    // The quotient fits in Q_W bits, so the upper numerator bits start below the divisor.
    always_comb
    begin
        for (int s = 1; s <= Q_W; s++)
        begin
            trial[s] = {rem_reg[s-1], low_reg[s-1][Q_W-1]};
            if (trial[s] >= {1'b0, den_reg[s-1]})
            begin
                rem_next[s] = DEN_W'(trial[s] - {1'b0, den_reg[s-1]});
                q_bit[s]    = 1'b1;
            end
            else
            begin
                rem_next[s] = DEN_W'(trial[s]);
                q_bit[s]    = 1'b0;
            end
        end
    end

    assign out_valid = v_reg[Q_W];
    assign out_q     = q_reg[Q_W];
    assign out_side  = side_reg[Q_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= Q_W; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= Q_W; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DEN_W'(in_num >> Q_W);
            low_reg[0]  <= in_num[Q_W-1:0];
            q_reg[0]    <= '0;
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
            for (int s = 1; s <= Q_W; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                low_reg[s]  <= low_reg[s-1] << 1;
                q_reg[s]    <= {q_reg[s-1][Q_W-2:0], q_bit[s]};
                den_reg[s]  <= den_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

endmodule

// File: hdl/sdz_back.sv
// Back part: rescales the magnitude, applies the direction and holds the result.
module sdz_back
    import sdz_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   fifo_empty,
    input  item_t                  pop_item,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] tuned_x,
    output logic [SAMPLE_BITS-1:0] tuned_y,
    output logic                   inside_deadzone
);

    logic                   en;
    logic [NUM_W-1:0]       mag_num;
    logic [DEN_W-1:0]       mag_den;
    logic                   m_valid;
    logic [Q_W-1:0]         m_q;
    side_t                  m_side;
    logic [MAG_W-1:0]       mag;
    logic [NUM_W-1:0]       num_x, num_y;
    logic                   x_valid;
    logic [Q_W-1:0]         qx, qy;
    side_t                  x_side;
    logic [Q_W-1:0]         neg_x, neg_y;
    logic [SAMPLE_BITS-1:0] res_x, res_y;

    logic                   out_v_reg;
    logic [SAMPLE_BITS-1:0] tx_reg, ty_reg;
    logic                   inside_reg;

    assign en  = !out_v_reg || out_ready;
    assign pop = en && !fifo_empty;

    assign mag_num = NUM_W'(pop_item.diff) * NUM_W'(cfg.sens);
    assign mag_den = DEN_W'(14'(7'd100 - cfg.dz) * 14'd100);

    sdz_div u_div_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pop),
        .in_num    (mag_num),
        .in_den    (mag_den),
        .in_side   (pop_item.side),
        .out_valid (m_valid),
        .out_q     (m_q),
        .out_side  (m_side)
    );

    assign mag   = (m_q > Q_W'(ONE_VAL)) ? MAG_W'(ONE_VAL) : m_q[MAG_W-1:0];
    assign num_x = NUM_W'(NUM_W'(m_side.ax) * NUM_W'(mag));
    assign num_y = NUM_W'(NUM_W'(m_side.ay) * NUM_W'(mag));

    sdz_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid),
        .in_num    (num_x),
        .in_den    (DEN_W'(m_side.len_full)),
        .in_side   (m_side),
        .out_valid (x_valid),
        .out_q     (qx),
        .out_side  (x_side)
    );

    sdz_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid),
        .in_num    (num_y),
        .in_den    (DEN_W'(m_side.len_full)),
        .in_side   (m_side),
        .out_valid (),
        .out_q     (qy),
        .out_side  ()
    );

    // Negative results may reach minus full scale; positive ones stop one step short.
    assign neg_x = Q_W'(0) - qx;
    assign neg_y = Q_W'(0) - qy;

    always_comb
    begin
        if (x_side.dz_hit)
        begin
            res_x = '0;
            res_y = '0;
        end
        else
        begin
            if (x_side.nx)
            begin
                res_x = neg_x[SAMPLE_BITS-1:0];
            end
            else
            begin
                res_x = (qx >= Q_W'(ONE_VAL)) ? ONE_VAL - 1'b1 : qx[SAMPLE_BITS-1:0];
            end
            if (x_side.ny)
            begin
                res_y = neg_y[SAMPLE_BITS-1:0];
            end
            else
            begin
                res_y = (qy >= Q_W'(ONE_VAL)) ? ONE_VAL - 1'b1 : qy[SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= x_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_reg     <= res_x;
            ty_reg     <= res_y;
            inside_reg <= x_side.dz_hit;
        end
    end

    assign out_valid       = out_v_reg;
    assign tuned_x         = tx_reg;
    assign tuned_y         = ty_reg;
    assign inside_deadzone = inside_reg;

endmodule

// File: hdl/stick_radial_deadzone_scaler_unit.sv
// Top level of the stick radial dead zone scaler.
//
// The block conditions two-axis joystick samples in signed Q1.15. A sample is
// taken on the input channel when in_valid and in_ready are both high; the
// conditioned item appears on the output channel and leaves when out_valid and
// out_ready are both high. Each result item carries tuned_x, tuned_y and the
// inside_deadzone flag, in the order the samples arrived.
//
// Throughput is one item per cycle while the receiver keeps out_ready high. A sample
// passes in the front part through the input register, the squared sum, one stage
// per root bit of the square root and the dead zone test, then through the queue,
// and in the back part through two 18-stage dividers in series and the output
// register.
//
// When the receiver holds out_ready low, the back part stops and holds its result.
// The front part keeps taking items until the four-entry queue fills; only then
// does in_ready fall.
//
// Reset clears every valid bit and the queue and sets the dead zone to 20 percent
// and the sensitivity to 100 percent. The configuration port writes one register
// per cycle when cfg_write_en is high; the block should be idle while it is used.
module stick_radial_deadzone_scaler_unit
    import sdz_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] stick_x,
    input  logic [SAMPLE_BITS-1:0] stick_y,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] tuned_x,
    output logic [SAMPLE_BITS-1:0] tuned_y,
    output logic                   inside_deadzone
);

    logic [DZ_W-1:0]   dz_reg;
    logic [SENS_W-1:0] sens_reg;
    cfg_t              cfg;

    logic  push, pop, fifo_full, fifo_empty;
    item_t push_item, pop_item;

    // Register writes; the raw values are kept and clamped where they are used.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg   <= DZ_RESET;
            sens_reg <= SENS_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_DEADZONE:    dz_reg   <= cfg_data[DZ_W-1:0];
                REG_SENSITIVITY: sens_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Clamp both settings into their working ranges.
    always_comb
    begin
        if (dz_reg < DZ_MIN)
        begin
            cfg.dz = DZ_MIN;
        end
        else if (dz_reg > DZ_MAX)
        begin
            cfg.dz = DZ_MAX;
        end
        else
        begin
            cfg.dz = dz_reg;
        end
        if (sens_reg < SENS_MIN)
        begin
            cfg.sens = SENS_MIN;
        end
        else if (sens_reg > SENS_MAX)
        begin
            cfg.sens = SENS_MAX;
        end
        else
        begin
            cfg.sens = sens_reg;
        end
    end

    sdz_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .stick_x   (stick_x),
        .stick_y   (stick_y),
        .fifo_full (fifo_full),
        .push      (push),
        .push_item (push_item)
    );

    sdz_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (fifo_empty)
    );

    sdz_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .fifo_empty      (fifo_empty),
        .pop_item        (pop_item),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .tuned_x         (tuned_x),
        .tuned_y         (tuned_y),
        .inside_deadzone (inside_deadzone)
    );

endmodule

// File: hdl/sdz_checker.sv
// Port-level checks of the stick radial dead zone scaler and their binding.
module sdz_checker
    import sdz_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cfg_write_en,
    input logic [CFG_IDX_W-1:0]   cfg_index,
    input logic [CFG_W-1:0]       cfg_data,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic [SAMPLE_BITS-1:0] stick_x,
    input logic [SAMPLE_BITS-1:0] stick_y,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] tuned_x,
    input logic [SAMPLE_BITS-1:0] tuned_y,
    input logic                   inside_deadzone
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(tuned_x) && $stable(tuned_y) && $stable(inside_deadzone))
        else $error("result payload changed while stalled");

    // Items inside the dead zone come out as zero.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_deadzone |-> tuned_x == '0 && tuned_y == '0)
        else $error("nonzero output inside the dead zone");

    // Nothing is offered right after reset is released.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result offered right after reset");

endmodule

bind stick_radial_deadzone_scaler_unit sdz_checker u_sdz_checker (.*);

// File: test/stick_radial_deadzone_scaler_unit_tb.sv
// Testbench of the stick radial dead zone scaler: randomized items checked against a model.
`timescale 1ns / 100ps

import sdz_pkg::*;

typedef struct {
    logic [SAMPLE_BITS-1:0] tx;
    logic [SAMPLE_BITS-1:0] ty;
    logic                   dz_flag;
} tuned_item_t;

class deadzone_scoreboard;
    tuned_item_t tuned_q[$];
    int          mismatches;
    logic [7:0]  dz_reg;
    logic [7:0]  sens_reg;

    function new();
        mismatches = 0;
        dz_reg     = 8'd20;
        sens_reg   = 8'd100;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        if (idx == REG_DEADZONE)
            dz_reg = {1'b0, data[6:0]};
        else if (idx == REG_SENSITIVITY)
            sens_reg = data;
    endfunction

    function bit [63:0] root_floor(bit [63:0] v);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function logic [SAMPLE_BITS-1:0] scale_axis(bit [63:0] a, bit neg, bit [63:0] mag,
                                                bit [63:0] full_len);
        bit [63:0] q;
        q = (a * mag) / full_len;
        if (neg)
            return SAMPLE_BITS'(64'd0 - q);
        if (q > 64'd32767)
            q = 64'd32767;
        return SAMPLE_BITS'(q);
    endfunction

    // Works out the conditioned item for one accepted sample.
    function void note_sample(logic [SAMPLE_BITS-1:0] x, logic [SAMPLE_BITS-1:0] y);
        tuned_item_t e;
        bit [63:0]   ax;
        bit [63:0]   ay;
        bit [63:0]   dz;
        bit [63:0]   sens;
        bit [63:0]   full_len;
        bit [63:0]   len;
        bit [63:0]   mag;
        ax = x[SAMPLE_BITS-1] ? 64'd65536 - x : 64'(x);
        ay = y[SAMPLE_BITS-1] ? 64'd65536 - y : 64'(y);
        dz = dz_reg < 5 ? 5 : (dz_reg > 60 ? 60 : dz_reg);
        sens = sens_reg < 50 ? 50 : (sens_reg > 200 ? 200 : sens_reg);
        full_len = root_floor(ax * ax + ay * ay);
        len = full_len > 64'd32768 ? 64'd32768 : full_len;
        if (len * 100 <= dz * 32768)
        begin
            e.tx = '0;
            e.ty = '0;
            e.dz_flag = 1'b1;
        end
        else
        begin
            mag = ((len * 100 - dz * 32768) * sens) / ((100 - dz) * 100);
            if (mag > 64'd32768)
                mag = 64'd32768;
            e.tx = scale_axis(ax, x[SAMPLE_BITS-1], mag, full_len);
            e.ty = scale_axis(ay, y[SAMPLE_BITS-1], mag, full_len);
            e.dz_flag = 1'b0;
        end
        tuned_q.push_back(e);
    endfunction

    function void check_result(logic [SAMPLE_BITS-1:0] tx, logic [SAMPLE_BITS-1:0] ty,
                               logic flag);
        tuned_item_t e;
        if (tuned_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected item: x=%h y=%h in=%b", tx, ty, flag);
            return;
        end
        e = tuned_q.pop_front();
        if (tx !== e.tx || ty !== e.ty || flag !== e.dz_flag)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected x=%h y=%h in=%b, got x=%h y=%h in=%b",
                         e.tx, e.ty, e.dz_flag, tx, ty, flag);
        end
    endfunction
endclass

module stick_radial_deadzone_scaler_unit_tb;

    localparam int IDLE_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 118;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [SAMPLE_BITS-1:0] stick_x;
    logic [SAMPLE_BITS-1:0] stick_y;
    logic                   out_valid;
    logic                   out_ready;
    logic [SAMPLE_BITS-1:0] tuned_x;
    logic [SAMPLE_BITS-1:0] tuned_y;
    logic                   inside_deadzone;

    deadzone_scoreboard sb;
    // When set, neither side idles, so the pipeline runs at full rate.
    bit burst;
    int out_hold;
    int idle_cycles;

    stick_radial_deadzone_scaler_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .stick_x(stick_x),
        .stick_y(stick_y),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .tuned_x(tuned_x),
        .tuned_y(tuned_y),
        .inside_deadzone(inside_deadzone)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // The receiver checks every accepted item against the oldest expectation,
    // then decides whether to stall on the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(tuned_x, tuned_y, inside_deadzone);
        if (out_hold > 0)
        begin
            out_hold <= out_hold - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!burst && $urandom_range(0, 3) == 0)
                out_hold <= gap_len();
        end
    end

    // Watchdog: a long run of cycles with nothing accepted means the block hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("stick_radial_deadzone_scaler_unit_tb failed");
                $finish;
            end
        end
    end

    // Holds the write enable high for one edge; the caller lowers it after the
    // last write so that it never falls and rises in the same step.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic set_tuning(logic [CFG_W-1:0] dz, logic [CFG_W-1:0] sens);
        write_reg(REG_DEADZONE, dz);
        write_reg(REG_SENSITIVITY, sens);
        cfg_write_en <= 1'b0;
    endtask

    // Presents one sample and waits until the block takes it.
    task automatic send_sample(logic [SAMPLE_BITS-1:0] x, logic [SAMPLE_BITS-1:0] y);
        int gap;
        in_valid <= 1'b1;
        stick_x <= x;
        stick_y <= y;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_sample(x, y);
        gap = burst ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering samples, waits until every expected item has come out,
    // then lets the pipeline drain completely so that a register write cannot
    // hit an item in flight.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.tuned_q.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] edge_value();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h8001;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    // Mixes full-range samples with ones near the dead zone edge and on the axes.
    task automatic random_phase(int count);
        logic [SAMPLE_BITS-1:0] x;
        logic [SAMPLE_BITS-1:0] y;
        int mode;
        for (int i = 0; i < count; i++)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 4)
            begin
                x = SAMPLE_BITS'($urandom);
                y = SAMPLE_BITS'($urandom);
            end
            else if (mode < 7)
            begin
                x = SAMPLE_BITS'($urandom_range(0, 42000) - 21000);
                y = SAMPLE_BITS'($urandom_range(0, 42000) - 21000);
            end
            else if (mode < 8)
            begin
                x = SAMPLE_BITS'($urandom);
                y = '0;
            end
            else if (mode < 9)
            begin
                x = '0;
                y = SAMPLE_BITS'($urandom);
            end
            else
            begin
                x = edge_value();
                y = edge_value();
            end
            send_sample(x, y);
        end
    endtask

    initial
    begin
        sb = new();
        burst = 1'b0;
        out_hold = 0;
        idle_cycles = 0;
        rst_n <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        stick_x <= '0;
        stick_y <= '0;
        out_ready <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples under the reset tuning: zero, the corners, the
        // negative full scale, lengths past one, and both sides of the edge.
        send_sample(16'h0000, 16'h0000);
        send_sample(16'h7FFF, 16'h0000);
        send_sample(16'h8000, 16'h0000);
        send_sample(16'h0000, 16'h7FFF);
        send_sample(16'h0000, 16'h8000);
        send_sample(16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h0001, 16'hFFFF);
        send_sample(16'd6553, 16'h0000);
        send_sample(16'd6554, 16'h0000);
        send_sample(16'h0000, -16'sd6554);
        send_sample(16'd4634, 16'd4634);
        send_sample(16'd4635, 16'd4635);
        send_sample(16'h5A82, 16'h5A82);
        send_sample(16'hA57E, 16'h5A82);
        send_sample(16'h4000, 16'hC000);
        random_phase(ITEMS_PER_PHASE - 18);
        drain();

        // Out-of-range values exercise the clamps, including the 7-bit mask
        // on the dead zone register, then the clamp limits themselves.
        set_tuning(8'd0, 8'd0);
        random_phase(ITEMS_PER_PHASE);
        drain();
        set_tuning(8'hFF, 8'hFF);
        send_sample(16'h7FFF, 16'h0000);
        send_sample(16'h7FFF, 16'h7FFF);
        random_phase(ITEMS_PER_PHASE);
        drain();
        set_tuning(8'd5, 8'd50);
        burst = 1'b1;
        random_phase(ITEMS_PER_PHASE);
        burst = 1'b0;
        drain();
        set_tuning(8'd60, 8'd200);
        send_sample(16'h7FFF, 16'h0000);
        send_sample(16'h0000, 16'h7FFF);
        random_phase(ITEMS_PER_PHASE);
        drain();
        set_tuning(8'd100, 8'd150);
        random_phase(ITEMS_PER_PHASE);
        drain();
        for (int p = 0; p < 2; p++)
        begin
            set_tuning(CFG_W'($urandom), CFG_W'($urandom));
            random_phase(ITEMS_PER_PHASE);
            drain();
        end

        if (sb.mismatches == 0)
            $display("stick_radial_deadzone_scaler_unit_tb passed");
        else
            $display("stick_radial_deadzone_scaler_unit_tb failed");
        $finish;
    end

endmodule
